/* rtl/core/hmt_pkg.sv */
package hmt_pkg;

	typedef enum logic [3:0] {
		ST_SKIP  = 4'd0,
		ST_TEXT  = 4'd1,
		ST_PRE   = 4'd2,
		ST_PRE2  = 4'd3,
		ST_NAME  = 4'd4,
		ST_BODY  = 4'd5,
		ST_ANAME = 4'd6,
		ST_AEQ   = 4'd7,
		ST_AQUOT = 4'd8,
		ST_ABARE = 4'd9
	} state_t;

	typedef enum logic [1:0] {
		TK_DATA  = 2'd0,
		TK_OPEN  = 2'd1,
		TK_CLOSE = 2'd2,
		TK_ATTR  = 2'd3
	} tok_t;

	localparam logic EV_CHAR = 1'b0;
	localparam logic EV_END  = 1'b1;

	localparam logic PART_NAME  = 1'b0;
	localparam logic PART_VALUE = 1'b1;

	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int RES_DEPTH = 4;
	localparam int RES_AW    = 2;
	localparam int RES_CW    = 3;

	typedef struct packed {
		logic       event_kind;
		tok_t       token_kind;
		logic       attr_part;
		logic [7:0] out_char;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} step_out_t;

	typedef struct packed {
		logic              room2;
		logic [RES_CW-1:0] level;
	} fifo_stat_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
	endfunction

	function automatic logic is_name_rest(input logic [7:0] c);
		return is_letter(c) || ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_DASH);
	endfunction

	function automatic state_t body_next(input logic [7:0] c);
		state_t s;
		s = ST_BODY;
		if (!is_ws(c)) begin
			if (c == CH_GT) s = ST_SKIP;
			else if (is_letter(c)) s = ST_ANAME;
			else if (c == CH_EQ) s = ST_AEQ;
		end
		return s;
	endfunction

	function automatic res_t mk_char(input tok_t k, input logic p, input logic [7:0] c);
		res_t r;
		r.event_kind = EV_CHAR;
		r.token_kind = k;
		r.attr_part  = p;
		r.out_char   = c;
		r.last       = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_end(input tok_t k);
		res_t r;
		r.event_kind = EV_END;
		r.token_kind = k;
		r.attr_part  = PART_NAME;
		r.out_char   = 8'h00;
		r.last       = 1'b0;
		return r;
	endfunction

endpackage

/* rtl/core/hmt_step.sv */
module hmt_step (
	input  hmt_pkg::state_t    state,
	input  logic               tag_close,
	input  logic [7:0]         c,
	input  logic               eos,
	output hmt_pkg::state_t    state_nxt,
	output logic               tag_close_nxt,
	output hmt_pkg::step_out_t res
);

	hmt_pkg::tok_t tk;
	logic          a_v;
	hmt_pkg::res_t a;
	logic          body_call;
	logic          b_v;
	hmt_pkg::res_t b;

	assign tk = tag_close ? hmt_pkg::TK_CLOSE : hmt_pkg::TK_OPEN;

	// next state
	always_comb begin
		state_nxt     = state;
		tag_close_nxt = tag_close;
		if (eos) begin
			state_nxt     = hmt_pkg::ST_SKIP;
			tag_close_nxt = 1'b0;
		end else begin
			unique case (state)
				hmt_pkg::ST_TEXT: begin
					if (c == hmt_pkg::CH_LT) begin
						state_nxt     = hmt_pkg::ST_PRE;
						tag_close_nxt = 1'b0;
					end
				end
				hmt_pkg::ST_PRE, hmt_pkg::ST_PRE2: begin
					if (hmt_pkg::is_ws(c)) begin
						state_nxt = state;
					end else if (state == hmt_pkg::ST_PRE && c == hmt_pkg::CH_SLASH) begin
						state_nxt     = hmt_pkg::ST_PRE2;
						tag_close_nxt = 1'b1;
					end else if (hmt_pkg::is_letter(c)) begin
						state_nxt = hmt_pkg::ST_NAME;
					end else begin
						state_nxt = hmt_pkg::body_next(c);
					end
				end
				hmt_pkg::ST_NAME: begin
					if (!hmt_pkg::is_name_rest(c)) state_nxt = hmt_pkg::body_next(c);
				end
				hmt_pkg::ST_BODY: begin
					state_nxt = hmt_pkg::body_next(c);
				end
				hmt_pkg::ST_ANAME: begin
					if (hmt_pkg::is_name_rest(c)) state_nxt = state;
					else if (c == hmt_pkg::CH_EQ) state_nxt = hmt_pkg::ST_AEQ;
					else state_nxt = hmt_pkg::body_next(c);
				end
				hmt_pkg::ST_AEQ: begin
					if (hmt_pkg::is_ws(c)) state_nxt = state;
					else if (c == hmt_pkg::CH_QUOTE) state_nxt = hmt_pkg::ST_AQUOT;
					else if (hmt_pkg::is_letter(c)) state_nxt = hmt_pkg::ST_ABARE;
					else state_nxt = hmt_pkg::body_next(c);
				end
				hmt_pkg::ST_AQUOT: begin
					if (c == hmt_pkg::CH_QUOTE) state_nxt = hmt_pkg::ST_BODY;
				end
				hmt_pkg::ST_ABARE: begin
					if (!hmt_pkg::is_name_rest(c)) state_nxt = hmt_pkg::body_next(c);
				end
				default: begin
					if (hmt_pkg::is_ws(c)) begin
						state_nxt = hmt_pkg::ST_SKIP;
					end else if (c == hmt_pkg::CH_LT) begin
						state_nxt     = hmt_pkg::ST_PRE;
						tag_close_nxt = 1'b0;
					end else begin
						state_nxt = hmt_pkg::ST_TEXT;
					end
				end
			endcase
		end
	end

	// results
	always_comb begin
		a_v       = 1'b0;
		a         = hmt_pkg::mk_end(hmt_pkg::TK_DATA);
		body_call = 1'b0;
		if (eos) begin
			unique case (state)
				hmt_pkg::ST_TEXT: begin
					a_v = 1'b1;
					a   = hmt_pkg::mk_end(hmt_pkg::TK_DATA);
				end
				hmt_pkg::ST_PRE, hmt_pkg::ST_PRE2, hmt_pkg::ST_NAME: begin
					a_v = 1'b1;
					a   = hmt_pkg::mk_end(tk);
				end
				hmt_pkg::ST_ANAME, hmt_pkg::ST_AEQ, hmt_pkg::ST_AQUOT, hmt_pkg::ST_ABARE: begin
					a_v = 1'b1;
					a   = hmt_pkg::mk_end(hmt_pkg::TK_ATTR);
				end
				default: a_v = 1'b0;
			endcase
		end else begin
			unique case (state)
				hmt_pkg::ST_TEXT: begin
					a_v = 1'b1;
					if (c == hmt_pkg::CH_LT) a = hmt_pkg::mk_end(hmt_pkg::TK_DATA);
					else if (c == hmt_pkg::CH_NL)
						a = hmt_pkg::mk_char(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME,
							hmt_pkg::CH_SPACE);
					else a = hmt_pkg::mk_char(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME, c);
				end
				hmt_pkg::ST_PRE, hmt_pkg::ST_PRE2: begin
					if (hmt_pkg::is_ws(c)) begin
						a_v = 1'b0;
					end else if (state == hmt_pkg::ST_PRE && c == hmt_pkg::CH_SLASH) begin
						a_v = 1'b0;
					end else if (hmt_pkg::is_letter(c)) begin
						a_v = 1'b1;
						a   = hmt_pkg::mk_char(tk, hmt_pkg::PART_NAME, c);
					end else begin
						a_v       = 1'b1;
						a         = hmt_pkg::mk_end(tk);
						body_call = 1'b1;
					end
				end
				hmt_pkg::ST_NAME: begin
					a_v = 1'b1;
					if (hmt_pkg::is_name_rest(c)) begin
						a = hmt_pkg::mk_char(tk, hmt_pkg::PART_NAME, c);
					end else begin
						a         = hmt_pkg::mk_end(tk);
						body_call = 1'b1;
					end
				end
				hmt_pkg::ST_BODY: body_call = 1'b1;
				hmt_pkg::ST_ANAME: begin
					if (hmt_pkg::is_name_rest(c)) begin
						a_v = 1'b1;
						a   = hmt_pkg::mk_char(hmt_pkg::TK_ATTR, hmt_pkg::PART_NAME, c);
					end else if (c != hmt_pkg::CH_EQ) begin
						a_v       = 1'b1;
						a         = hmt_pkg::mk_end(hmt_pkg::TK_ATTR);
						body_call = 1'b1;
					end
				end
				hmt_pkg::ST_AEQ: begin
					if (hmt_pkg::is_letter(c)) begin
						a_v = 1'b1;
						a   = hmt_pkg::mk_char(hmt_pkg::TK_ATTR, hmt_pkg::PART_VALUE, c);
					end else if (!hmt_pkg::is_ws(c) && c != hmt_pkg::CH_QUOTE) begin
						a_v       = 1'b1;
						a         = hmt_pkg::mk_end(hmt_pkg::TK_ATTR);
						body_call = 1'b1;
					end
				end
				hmt_pkg::ST_AQUOT: begin
					a_v = 1'b1;
					if (c == hmt_pkg::CH_QUOTE) a = hmt_pkg::mk_end(hmt_pkg::TK_ATTR);
					else a = hmt_pkg::mk_char(hmt_pkg::TK_ATTR, hmt_pkg::PART_VALUE, c);
				end
				hmt_pkg::ST_ABARE: begin
					a_v = 1'b1;
					if (hmt_pkg::is_name_rest(c)) begin
						a = hmt_pkg::mk_char(hmt_pkg::TK_ATTR, hmt_pkg::PART_VALUE, c);
					end else begin
						a         = hmt_pkg::mk_end(hmt_pkg::TK_ATTR);
						body_call = 1'b1;
					end
				end
				default: begin
					if (!hmt_pkg::is_ws(c) && c != hmt_pkg::CH_LT) begin
						a_v = 1'b1;
						a   = hmt_pkg::mk_char(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME, c);
					end
				end
			endcase
		end
	end

	// tag content byte
	always_comb begin
		b_v = 1'b0;
		b   = hmt_pkg::mk_end(hmt_pkg::TK_CLOSE);
		if (body_call && !hmt_pkg::is_ws(c)) begin
			if (c == hmt_pkg::CH_SLASH) begin
				b_v = 1'b1;
			end else if (hmt_pkg::is_letter(c)) begin
				b_v = 1'b1;
				b   = hmt_pkg::mk_char(hmt_pkg::TK_ATTR, hmt_pkg::PART_NAME, c);
			end
		end
	end

	always_comb begin
		res.n       = {1'b0, a_v} + {1'b0, b_v};
		res.r0      = a_v ? a : b;
		res.r0.last = !(a_v && b_v);
		res.r1      = b;
		res.r1.last = 1'b1;
	end

endmodule

/* rtl/core/hmt_res_fifo.sv */
module hmt_res_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  hmt_pkg::res_t       push0,
	input  hmt_pkg::res_t       push1,
	input  logic                pop,
	output logic                head_valid,
	output hmt_pkg::res_t       head,
	output hmt_pkg::fifo_stat_t stat
);

	hmt_pkg::res_t                 mem_q [hmt_pkg::RES_DEPTH];
	logic [hmt_pkg::RES_AW-1:0]    wr_q;
	logic [hmt_pkg::RES_AW-1:0]    rd_q;
	logic [hmt_pkg::RES_CW-1:0]    cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_n;
			rd_q  <= rd_q + {{(hmt_pkg::RES_AW-1){1'b0}}, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {{(hmt_pkg::RES_CW-1){1'b0}}, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) mem_q[wr_q] <= push0;
		if (push_n == 2'd2) mem_q[wr_q + 2'd1] <= push1;
	end

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_q];
	assign stat.room2 = (cnt_q <= 3'(hmt_pkg::RES_DEPTH - 2));
	assign stat.level = cnt_q;

endmodule

/* rtl/core/html_markup_tokenizer_core.sv */
// channel | handshake           | payload
// in      | in_valid, in_ready   | in_byte, end_of_stream
// out     | out_valid, out_ready | event_kind, token_kind, attr_part, out_char, last
//
// one byte a cycle enters the input register while the queue has room for two; the scan step runs in the next cycle
// an item with two results writes both into the four-entry result queue at once
// the input register waits while the queue has fewer than two free entries
// from input accept to first result an item passes the input register, then the result queue
// reset: scan state to text whitespace skip, both stages empty
module html_markup_tokenizer_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       event_kind,
	output logic [1:0] token_kind,
	output logic       attr_part,
	output logic [7:0] out_char,
	output logic       last
);

	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eos_s1;
	hmt_pkg::state_t     state_q;
	logic                tag_close_q;
	hmt_pkg::state_t     state_nxt;
	logic                tag_close_nxt;
	hmt_pkg::step_out_t  step_res;
	hmt_pkg::fifo_stat_t fifo_stat;
	hmt_pkg::res_t       head;
	logic                adv;
	logic [1:0]          push_n;

	assign adv      = valid_s1 && fifo_stat.room2;
	assign in_ready = !valid_s1 || adv;
	assign push_n   = adv ? step_res.n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= hmt_pkg::ST_SKIP;
			tag_close_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) valid_s1 <= 1'b1;
			else if (adv) valid_s1 <= 1'b0;
			if (adv) begin
				state_q     <= state_nxt;
				tag_close_q <= tag_close_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eos_s1  <= end_of_stream;
		end
	end

	hmt_step u_step (
		.state         (state_q),
		.tag_close     (tag_close_q),
		.c             (byte_s1),
		.eos           (eos_s1),
		.state_nxt     (state_nxt),
		.tag_close_nxt (tag_close_nxt),
		.res           (step_res)
	);

	hmt_res_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push0      (step_res.r0),
		.push1      (step_res.r1),
		.pop        (out_valid && out_ready),
		.head_valid (out_valid),
		.head       (head),
		.stat       (fifo_stat)
	);

	assign event_kind = head.event_kind;
	assign token_kind = head.token_kind;
	assign attr_part  = head.attr_part;
	assign out_char   = head.out_char;
	assign last       = head.last;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.level <= 3'(hmt_pkg::RES_DEPTH))
		else $error("result queue over capacity");

	a_eos_resets: assert property (@(posedge clk) disable iff (!arst_n)
		adv && eos_s1 |=> state_q == hmt_pkg::ST_SKIP && !tag_close_q)
		else $error("end of stream did not return to text skip");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> fifo_stat.level <= 3'(hmt_pkg::RES_DEPTH - 2))
		else $error("results pushed without room");

	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		adv && step_res.n == 2'd2 |-> !step_res.r0.last && step_res.r1.last)
		else $error("last flag wrong on two-result item");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

	localparam int HOLD_CYCLES = 300;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 370;

	typedef struct packed {
		logic [7:0]    b;
		logic          eos;
		logic          typed;
		logic [1:0]    n;
		hmt_pkg::res_t r0;
		hmt_pkg::res_t r1;
	} markup_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = 8'h00;
	logic       end_of_stream = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       event_kind;
	logic [1:0] token_kind;
	logic       attr_part;
	logic [7:0] out_char;
	logic       last;

	markup_item_t     markup_q[$];
	markup_item_t     offered;
	hmt_pkg::res_t    byte_events[$];
	hmt_pkg::res_t    pending_events[$];
	hmt_pkg::state_t  scan;
	logic             tag_closing;
	int               send_idle = 0;
	int               recv_stall = 0;
	logic             hold_req = 1'b0;
	int               hold_cnt = 0;
	int               quiet = 0;
	int               mismatches = 0;

	localparam hmt_pkg::res_t NONE = '0;

	html_markup_tokenizer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.end_of_stream(end_of_stream),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.event_kind(event_kind),
		.token_kind(token_kind),
		.attr_part(attr_part),
		.out_char(out_char),
		.last(last)
	);

	always #1 clk = ~clk;

	function automatic hmt_pkg::res_t chr(hmt_pkg::tok_t k, logic p, logic [7:0] c, logic l);
		hmt_pkg::res_t r;
		r = '{event_kind: hmt_pkg::EV_CHAR, token_kind: k, attr_part: p,
			out_char: c, last: l};
		return r;
	endfunction

	function automatic hmt_pkg::res_t fin(hmt_pkg::tok_t k, logic l);
		hmt_pkg::res_t r;
		r = '{event_kind: hmt_pkg::EV_END, token_kind: k, attr_part: hmt_pkg::PART_NAME,
			out_char: 8'h00, last: l};
		return r;
	endfunction

	function automatic logic blank(logic [7:0] c);
		return c inside {8'h20, [8'h09:8'h0D]};
	endfunction

	function automatic logic alpha(logic [7:0] c);
		return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	endfunction

	function automatic logic word_char(logic [7:0] c);
		return alpha(c) || (c inside {[8'h30:8'h39]}) || c == hmt_pkg::CH_DASH;
	endfunction

	function automatic hmt_pkg::tok_t tag_tok();
		return tag_closing ? hmt_pkg::TK_CLOSE : hmt_pkg::TK_OPEN;
	endfunction

	function automatic void add_event(hmt_pkg::res_t r);
		byte_events.insert(byte_events.size(), r);
	endfunction

	// first byte of tag content
	function automatic void tag_content(logic [7:0] c);
		scan = hmt_pkg::ST_BODY;
		if (blank(c))
			return;
		if (c == hmt_pkg::CH_SLASH) begin
			add_event(fin(hmt_pkg::TK_CLOSE, 1'b0));
		end else if (c == hmt_pkg::CH_GT) begin
			scan = hmt_pkg::ST_SKIP;
		end else if (alpha(c)) begin
			add_event(chr(hmt_pkg::TK_ATTR, hmt_pkg::PART_NAME, c, 1'b0));
			scan = hmt_pkg::ST_ANAME;
		end else if (c == hmt_pkg::CH_EQ) begin
			scan = hmt_pkg::ST_AEQ;
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] c, logic eos);
		byte_events.delete();
		if (eos) begin
			case (scan)
				hmt_pkg::ST_TEXT: add_event(fin(hmt_pkg::TK_DATA, 1'b0));
				hmt_pkg::ST_PRE, hmt_pkg::ST_PRE2, hmt_pkg::ST_NAME:
					add_event(fin(tag_tok(), 1'b0));
				hmt_pkg::ST_ANAME, hmt_pkg::ST_AEQ, hmt_pkg::ST_AQUOT, hmt_pkg::ST_ABARE:
					add_event(fin(hmt_pkg::TK_ATTR, 1'b0));
				default: ;
			endcase
			scan = hmt_pkg::ST_SKIP;
			tag_closing = 1'b0;
			return;
		end
		case (scan)
			hmt_pkg::ST_TEXT: begin
				if (c == hmt_pkg::CH_LT) begin
					add_event(fin(hmt_pkg::TK_DATA, 1'b0));
					tag_closing = 1'b0;
					scan = hmt_pkg::ST_PRE;
				end else begin
					add_event(chr(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME,
						c == hmt_pkg::CH_NL ? hmt_pkg::CH_SPACE : c, 1'b0));
				end
			end
			hmt_pkg::ST_PRE, hmt_pkg::ST_PRE2: begin
				if (blank(c)) begin
				end else if (scan == hmt_pkg::ST_PRE && c == hmt_pkg::CH_SLASH) begin
					tag_closing = 1'b1;
					scan = hmt_pkg::ST_PRE2;
				end else if (alpha(c)) begin
					add_event(chr(tag_tok(), hmt_pkg::PART_NAME, c, 1'b0));
					scan = hmt_pkg::ST_NAME;
				end else begin
					add_event(fin(tag_tok(), 1'b0));
					tag_content(c);
				end
			end
			hmt_pkg::ST_NAME: begin
				if (word_char(c)) begin
					add_event(chr(tag_tok(), hmt_pkg::PART_NAME, c, 1'b0));
				end else begin
					add_event(fin(tag_tok(), 1'b0));
					tag_content(c);
				end
			end
			hmt_pkg::ST_BODY: tag_content(c);
			hmt_pkg::ST_ANAME: begin
				if (word_char(c)) begin
					add_event(chr(hmt_pkg::TK_ATTR, hmt_pkg::PART_NAME, c, 1'b0));
				end else if (c == hmt_pkg::CH_EQ) begin
					scan = hmt_pkg::ST_AEQ;
				end else begin
					add_event(fin(hmt_pkg::TK_ATTR, 1'b0));
					tag_content(c);
				end
			end
			hmt_pkg::ST_AEQ: begin
				if (blank(c)) begin
				end else if (c == hmt_pkg::CH_QUOTE) begin
					scan = hmt_pkg::ST_AQUOT;
				end else if (alpha(c)) begin
					add_event(chr(hmt_pkg::TK_ATTR, hmt_pkg::PART_VALUE, c, 1'b0));
					scan = hmt_pkg::ST_ABARE;
				end else begin
					add_event(fin(hmt_pkg::TK_ATTR, 1'b0));
					tag_content(c);
				end
			end
			hmt_pkg::ST_AQUOT: begin
				if (c == hmt_pkg::CH_QUOTE) begin
					add_event(fin(hmt_pkg::TK_ATTR, 1'b0));
					scan = hmt_pkg::ST_BODY;
				end else begin
					add_event(chr(hmt_pkg::TK_ATTR, hmt_pkg::PART_VALUE, c, 1'b0));
				end
			end
			hmt_pkg::ST_ABARE: begin
				if (word_char(c)) begin
					add_event(chr(hmt_pkg::TK_ATTR, hmt_pkg::PART_VALUE, c, 1'b0));
				end else begin
					add_event(fin(hmt_pkg::TK_ATTR, 1'b0));
					tag_content(c);
				end
			end
			default: begin
				if (blank(c)) begin
					scan = hmt_pkg::ST_SKIP;
				end else if (c == hmt_pkg::CH_LT) begin
					tag_closing = 1'b0;
					scan = hmt_pkg::ST_PRE;
				end else begin
					add_event(chr(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME, c, 1'b0));
					scan = hmt_pkg::ST_TEXT;
				end
			end
		endcase
	endfunction

	function automatic void chk(string field, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic row(logic [7:0] b, logic eos, logic typed, logic [1:0] n,
		hmt_pkg::res_t r0, hmt_pkg::res_t r1);
		markup_item_t m;
		m = '{b: b, eos: eos, typed: typed, n: n, r0: r0, r1: r1};
		markup_q.insert(markup_q.size(), m);
	endtask

	task automatic put(logic [7:0] b, logic eos = 1'b0);
		row(b, eos, 1'b0, 2'd0, NONE, NONE);
	endtask

	function automatic logic [7:0] ws_byte();
		logic [7:0] w[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
		return w[$urandom_range(0, 5)];
	endfunction

	function automatic logic [7:0] letter_byte();
		return $urandom_range(0, 1) ? 8'($urandom_range(65, 90)) : 8'($urandom_range(97, 122));
	endfunction

	function automatic logic [7:0] rest_byte();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(48, 57));
			1: return hmt_pkg::CH_DASH;
			default: return letter_byte();
		endcase
	endfunction

	task automatic gen_word();
		put(letter_byte());
		repeat ($urandom_range(0, 6)) put(rest_byte());
	endtask

	task automatic gen_text();
		logic [7:0] b;
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 8))
				6: b = ws_byte();
				7, 8: do b = 8'($urandom_range(0, 255)); while (b == hmt_pkg::CH_LT);
				default: b = letter_byte();
			endcase
			put(b);
		end
	endtask

	task automatic gen_tag();
		logic [7:0] b;
		int na;
		put(hmt_pkg::CH_LT);
		if ($urandom_range(0, 3) == 0) put(ws_byte());
		if ($urandom_range(0, 2) == 0) begin
			put(hmt_pkg::CH_SLASH);
			if ($urandom_range(0, 3) == 0) put(ws_byte());
		end
		if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)));
		else gen_word();
		if ($urandom_range(0, 11) == 0) begin
			put(8'($urandom_range(0, 255)), 1'b1);
			return;
		end
		na = $urandom_range(0, 3);
		for (int k = 0; k < na; k++) begin
			put(ws_byte());
			gen_word();
			case ($urandom_range(0, 5))
				1, 2: begin
					put(hmt_pkg::CH_EQ);
					if ($urandom_range(0, 3) == 0) put(ws_byte());
					put(hmt_pkg::CH_QUOTE);
					repeat ($urandom_range(0, 6)) begin
						do b = 8'($urandom_range(0, 255)); while (b == hmt_pkg::CH_QUOTE);
						put(b);
					end
					if ($urandom_range(0, 15) == 0) begin
						put(8'h00, 1'b1);
						return;
					end
					put(hmt_pkg::CH_QUOTE);
				end
				3: begin
					put(hmt_pkg::CH_EQ);
					gen_word();
				end
				4: put(hmt_pkg::CH_EQ);
				5: put(8'($urandom_range(0, 255)));
				default: ;
			endcase
		end
		if ($urandom_range(0, 3) == 0) put(hmt_pkg::CH_SLASH);
		put(hmt_pkg::CH_GT);
	endtask

	task automatic gen_markup(int target);
		while (markup_q.size() < target) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6: gen_text();
				16, 17: repeat ($urandom_range(1, 4)) put(8'($urandom_range(0, 255)));
				18: put(8'($urandom_range(0, 255)), 1'b1);
				default: gen_tag();
			endcase
		end
	endtask

	task automatic drain();
		while (markup_q.size() != 0 || in_valid || pending_events.size() != 0)
			@(negedge clk);
	endtask

	// input side: offer items, predict on accept
	always @(posedge clk) begin : feed
		hmt_pkg::res_t r;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				tokenize_byte(offered.b, offered.eos);
				if (offered.typed) begin
					if (offered.n > 0)
						pending_events.insert(pending_events.size(), offered.r0);
					if (offered.n > 1)
						pending_events.insert(pending_events.size(), offered.r1);
				end else begin
					foreach (byte_events[i]) begin
						r = byte_events[i];
						r.last = (i == byte_events.size() - 1);
						pending_events.insert(pending_events.size(), r);
					end
				end
			end
			if (!in_valid || in_ready) begin
				if (markup_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					offered = markup_q.pop_front();
					in_valid <= 1'b1;
					in_byte <= offered.b;
					end_of_stream <= offered.eos;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output side: check events, stall and long hold-off
	always @(posedge clk) begin : drain_events
		hmt_pkg::res_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_events.size() == 0) begin
				$display("%0t: event with nothing expected: ev %0b kind %0d part %0b",
					$time, event_kind, token_kind, attr_part);
				$display("%0t: unexpected event char %0h last %0b", $time, out_char, last);
				mismatches++;
			end else begin
				e = pending_events.pop_front();
				chk("event_kind", 8'(e.event_kind), 8'(event_kind));
				chk("token_kind", 8'(e.token_kind), 8'(token_kind));
				chk("attr_part", 8'(e.attr_part), 8'(attr_part));
				chk("out_char", e.out_char, out_char);
				chk("last", 8'(e.last), 8'(last));
			end
		end
		if (hold_req && hold_cnt < HOLD_CYCLES) begin
			hold_cnt <= hold_cnt + 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= arst_n && ($urandom_range(0, 99) >= recv_stall);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		scan = hmt_pkg::ST_SKIP;
		tag_closing = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed items
		row(8'hFF, 1'b1, 1'b1, 2'd0, NONE, NONE);
		row(hmt_pkg::CH_SPACE, 1'b0, 1'b1, 2'd0, NONE, NONE);
		row(8'h00, 1'b0, 1'b1, 2'd1,
			chr(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME, 8'h00, 1'b1), NONE);
		row(hmt_pkg::CH_NL, 1'b0, 1'b1, 2'd1,
			chr(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME, hmt_pkg::CH_SPACE, 1'b1), NONE);
		row(8'hFF, 1'b0, 1'b1, 2'd1,
			chr(hmt_pkg::TK_DATA, hmt_pkg::PART_NAME, 8'hFF, 1'b1), NONE);
		row(8'h0A, 1'b1, 1'b1, 2'd1, fin(hmt_pkg::TK_DATA, 1'b1), NONE);
		row(hmt_pkg::CH_LT, 1'b0, 1'b1, 2'd0, NONE, NONE);
		put(8'h09);
		put(hmt_pkg::CH_SLASH);
		put(hmt_pkg::CH_SPACE);
		put("Z");
		put("0");
		put(hmt_pkg::CH_DASH);
		row(hmt_pkg::CH_GT, 1'b0, 1'b1, 2'd1, fin(hmt_pkg::TK_CLOSE, 1'b1), NONE);
		put("A");
		put(hmt_pkg::CH_LT);
		put("a");
		put(hmt_pkg::CH_SPACE);
		put("x");
		put(hmt_pkg::CH_EQ);
		put(hmt_pkg::CH_SPACE);
		put(hmt_pkg::CH_QUOTE);
		put(8'h80);
		put(hmt_pkg::CH_QUOTE);
		put("k");
		put(hmt_pkg::CH_EQ);
		put("v");
		row(hmt_pkg::CH_SLASH, 1'b0, 1'b1, 2'd2,
			fin(hmt_pkg::TK_ATTR, 1'b0), fin(hmt_pkg::TK_CLOSE, 1'b1));
		put("#");
		put(hmt_pkg::CH_EQ);
		row(hmt_pkg::CH_GT, 1'b0, 1'b1, 2'd1, fin(hmt_pkg::TK_ATTR, 1'b1), NONE);
		put(hmt_pkg::CH_LT);
		row("1", 1'b0, 1'b1, 2'd1, fin(hmt_pkg::TK_OPEN, 1'b1), NONE);
		put("q");
		row(8'h00, 1'b1, 1'b1, 2'd1, fin(hmt_pkg::TK_ATTR, 1'b1), NONE);
		put(hmt_pkg::CH_LT);
		row(8'h5A, 1'b1, 1'b1, 2'd1, fin(hmt_pkg::TK_OPEN, 1'b1), NONE);
		drain();

		// full rate, with one long hold-off of the receiver
		gen_markup(PHASE_ITEMS);
		hold_req = 1'b1;
		while (hold_cnt < HOLD_CYCLES) @(negedge clk);
		hold_req = 1'b0;
		drain();

		send_idle = 62;
		gen_markup(PHASE_ITEMS);
		drain();

		send_idle = 0;
		recv_stall = 62;
		gen_markup(PHASE_ITEMS);
		drain();

		send_idle = 31;
		recv_stall = 31;
		gen_markup(PHASE_ITEMS);
		drain();

		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/hmt_pkg.sv
rtl/core/hmt_step.sv
rtl/core/hmt_res_fifo.sv
rtl/core/html_markup_tokenizer_core.sv
tb/tb.sv
